### sv/krt_pkg.sv
`default_nettype none

package krt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FILL_W      = 8;

    // Field widths
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // One stored record
    typedef struct packed {
        logic        [WORD_W-1:0] price;
        logic signed [WORD_W-1:0] quantity;
        logic signed [WORD_W-1:0] key;
    } t_record;

endpackage

`default_nettype wire

### sv/keyed_record_table.sv
`default_nettype none

// Channel  Dir  tdata fields, low bit up                                     tuser
// s_axis   in   item_key[31:0] new_quantity[63:32] new_price_bits[95:64]     op[1:0]
// m_axis   out  found_quantity[31:0] found_price_bits[63:32] fill_level[71:64] status[1:0]
//
// One transaction at a time. The key scan visits each slot with one record memory read
// and one key compare; a delete then moves each later record down one slot, a read
// and then a write, through the separate memory read and write ports. An add to a full
// table skips the scan; tready returns in the cycle the result turns valid. The result
// sits in an output register, so a new transaction is taken while it waits; the response
// state holds while that register is still occupied. Reset empties the table; no memory
// clearing is needed since only filled slots are read.

module keyed_record_table (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [95:0]  i_s_axis_tdata,   // item_key, new_quantity, new_price_bits
    input  wire logic [1:0]   i_s_axis_tuser,   // op
    // result stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [71:0]       o_m_axis_tdata,   // found_quantity, found_price_bits, fill_level
    output logic [1:0]        o_m_axis_tuser    // status
);

    localparam int W  = krt_pkg::WORD_W;
    localparam int AW = krt_pkg::ADDR_W;
    localparam int CW = krt_pkg::CNT_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    localparam logic [CW-1:0] DEPTH_CNT = CW'(krt_pkg::TABLE_DEPTH);

    logic [2:0]                     r_state, n_state;
    logic [CW-1:0]                  r_idx, n_idx;
    logic [CW-1:0]                  r_count, n_count;
    logic [krt_pkg::OP_W-1:0]       r_op, n_op;
    logic signed [W-1:0]            r_key, n_key;
    logic signed [W-1:0]            r_qty, n_qty;
    logic [W-1:0]                   r_price, n_price;
    logic [krt_pkg::STATUS_W-1:0]   r_status, n_status;
    logic signed [W-1:0]            r_fq, n_fq;
    logic [W-1:0]                   r_fp, n_fp;

    logic                           r_out_valid, n_out_valid;
    logic [krt_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic signed [W-1:0]            r_out_fq, n_out_fq;
    logic [W-1:0]                   r_out_fp, n_out_fp;
    logic [krt_pkg::FILL_W-1:0]     r_out_fill, n_out_fill;

    // Record memory, one port each for read and write
    krt_pkg::t_record               r_mem [krt_pkg::TABLE_DEPTH];
    krt_pkg::t_record               r_rd_data;
    logic                           mem_rd_en;
    logic [AW-1:0]                  mem_rd_addr;
    logic                           mem_wr_en;
    logic [AW-1:0]                  mem_wr_addr;
    krt_pkg::t_record               mem_wr_data;

    logic                           s_accept;
    logic                           out_free;
    logic [CW-1:0]                  idx_inc;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign idx_inc  = r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    // Sequencer: scan, compare, shift down, respond
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_op         = r_op;
        n_key        = r_key;
        n_qty        = r_qty;
        n_price      = r_price;
        n_status     = r_status;
        n_fq         = r_fq;
        n_fp         = r_fp;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_fq     = r_out_fq;
        n_out_fp     = r_out_fp;
        n_out_fill   = r_out_fill;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_idx[AW-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_idx[AW-1:0];
        mem_wr_data  = r_rd_data;

        // result register drains independently
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op     = i_s_axis_tuser;
                    n_key    = i_s_axis_tdata[W-1:0];
                    n_qty    = i_s_axis_tdata[2*W-1:W];
                    n_price  = i_s_axis_tdata[3*W-1:2*W];
                    n_status = krt_pkg::ST_OK;
                    n_fq     = '0;
                    n_fp     = '0;
                    n_idx    = '0;
                    if (i_s_axis_tuser == krt_pkg::OP_ADD && r_count == DEPTH_CNT) begin
                        n_status = krt_pkg::ST_FULL;
                        n_state  = S_RESP;
                    end else begin
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_idx == r_count) begin
                    // scanned every record without a match
                    if (r_op == krt_pkg::OP_ADD) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_count[AW-1:0];
                        mem_wr_data = '{price: r_price, quantity: r_qty, key: r_key};
                        n_count     = r_count + 1'b1;
                    end else begin
                        n_status    = krt_pkg::ST_NOT_FOUND;
                    end
                    n_state = S_RESP;
                end else begin
                    mem_rd_en = 1'b1;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (r_rd_data.key == r_key) begin
                    unique case (r_op)
                        krt_pkg::OP_ADD: begin
                            n_status = krt_pkg::ST_DUPLICATE;
                            n_state  = S_RESP;
                        end
                        krt_pkg::OP_SEARCH: begin
                            n_fq    = r_rd_data.quantity;
                            n_fp    = r_rd_data.price;
                            n_state = S_RESP;
                        end
                        krt_pkg::OP_UPDATE: begin
                            n_fq        = r_rd_data.quantity;
                            n_fp        = r_rd_data.price;
                            mem_wr_en   = 1'b1;
                            mem_wr_data = '{price: r_rd_data.price, quantity: r_qty,
                                            key: r_rd_data.key};
                            n_state     = S_RESP;
                        end
                        krt_pkg::OP_DELETE: begin
                            n_state = S_SH_RD;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_READ;
                end
            end
            S_SH_RD: begin
                if (idx_inc == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_RESP;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_inc[AW-1:0];
                    n_state     = S_SH_WR;
                end
            end
            S_SH_WR: begin
                // move the next record down one slot
                mem_wr_en = 1'b1;
                n_idx     = idx_inc;
                n_state   = S_SH_RD;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_fq     = r_fq;
                    n_out_fp     = r_fp;
                    n_out_fill   = krt_pkg::FILL_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_op         <= n_op;
        r_key        <= n_key;
        r_qty        <= n_qty;
        r_price      <= n_price;
        r_status     <= n_status;
        r_fq         <= n_fq;
        r_fp         <= n_fp;
        r_out_status <= n_out_status;
        r_out_fq     <= n_out_fq;
        r_out_fp     <= n_out_fp;
        r_out_fill   <= n_out_fill;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {r_out_fill, r_out_fp, r_out_fq};

`ifndef SYNTHESIS
    // fill count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("record count above table depth");

    // count moves by at most one per transaction, and only at its end
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_state == S_RESP))
        else $error("record count changed outside a finishing transaction");

    // a result is loaded only from the response state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_RESP))
        else $error("result appeared without a finished transaction");
`endif

endmodule

`default_nettype wire

### dv/keyed_record_table_tb.sv
module keyed_record_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One lookup request as it enters the table
    typedef struct packed {
        logic [krt_pkg::OP_W-1:0]          op;
        logic signed [krt_pkg::WORD_W-1:0] key;
        logic signed [krt_pkg::WORD_W-1:0] quantity;
        logic [krt_pkg::WORD_W-1:0]        price;
    } t_request;

    // One reply as it leaves the table
    typedef struct packed {
        logic [krt_pkg::STATUS_W-1:0]      status;
        logic signed [krt_pkg::WORD_W-1:0] quantity;
        logic [krt_pkg::WORD_W-1:0]        price;
        logic [krt_pkg::FILL_W-1:0]        fill;
    } t_reply;

    // Directed stimulus row; the reply is typed in only where has_reply is set
    typedef struct packed {
        t_request req;
        logic     has_reply;
        t_reply   reply;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [95:0]  i_s_axis_tdata = '0;   // item_key, new_quantity, new_price_bits
    logic [1:0]   i_s_axis_tuser = '0;   // op
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [71:0]  o_m_axis_tdata;        // found_quantity, found_price_bits, fill_level
    logic [1:0]   o_m_axis_tuser;        // status

    keyed_record_table u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the table contents
    krt_pkg::t_record record_model [krt_pkg::TABLE_DEPTH];
    int unsigned      record_total = 0;

    t_reply      expected_replies [$];
    int unsigned mismatch_count = 0;
    int unsigned sender_idle_pct = 26;
    int unsigned receiver_idle_pct = 82;
    bit          table_filling = 1'b1;

    t_row directed_rows [0:24] = '{
        // empty table: every lookup misses
        '{'{krt_pkg::OP_SEARCH, 32'sh0000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_NOT_FOUND, 32'sh0, 32'h0, 8'd0}},
        '{'{krt_pkg::OP_UPDATE, 32'shFFFF_FFFF, 32'sh0000_3039, 32'h0}, 1'b1,
          '{krt_pkg::ST_NOT_FOUND, 32'sh0, 32'h0, 8'd0}},
        '{'{krt_pkg::OP_DELETE, 32'sh8000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_NOT_FOUND, 32'sh0, 32'h0, 8'd0}},
        // fill with extreme keys, quantities and prices
        '{'{krt_pkg::OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd1}},
        '{'{krt_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0000_0000}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd2}},
        '{'{krt_pkg::OP_ADD, 32'sh0000_0000, 32'sh0000_0000, 32'h7F80_0000}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd3}},
        '{'{krt_pkg::OP_ADD, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'h3F80_0000}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd4}},
        // key already present
        '{'{krt_pkg::OP_ADD, 32'sh8000_0000, 32'sh0000_0001, 32'h0000_0001}, 1'b1,
          '{krt_pkg::ST_DUPLICATE, 32'sh0, 32'h0, 8'd4}},
        '{'{krt_pkg::OP_SEARCH, 32'sh8000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 8'd4}},
        '{'{krt_pkg::OP_SEARCH, 32'sh7FFF_FFFF, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh8000_0000, 32'h0000_0000, 8'd4}},
        // update returns the old quantity; price field of the request is ignored
        '{'{krt_pkg::OP_UPDATE, 32'sh0000_0000, 32'shFFFF_FFFF, 32'hAAAA_AAAA}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0000_0000, 32'h7F80_0000, 8'd4}},
        '{'{krt_pkg::OP_SEARCH, 32'sh0000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'shFFFF_FFFF, 32'h7F80_0000, 8'd4}},
        // delete of slot 0 shifts the rest down
        '{'{krt_pkg::OP_DELETE, 32'sh8000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd3}},
        '{'{krt_pkg::OP_SEARCH, 32'sh8000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_NOT_FOUND, 32'sh0, 32'h0, 8'd3}},
        '{'{krt_pkg::OP_SEARCH, 32'shFFFF_FFFF, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'shFFFF_FFFF, 32'h3F80_0000, 8'd3}},
        // delete of the last slot, then a miss on the same key
        '{'{krt_pkg::OP_DELETE, 32'shFFFF_FFFF, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd2}},
        '{'{krt_pkg::OP_DELETE, 32'shFFFF_FFFF, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_NOT_FOUND, 32'sh0, 32'h0, 8'd2}},
        // re-add a deleted key
        '{'{krt_pkg::OP_ADD, 32'sh8000_0000, 32'sh0000_0005, 32'h1234_5678}, 1'b0, '0},
        '{'{krt_pkg::OP_UPDATE, 32'sh1234_5678, 32'sh0000_0007, 32'h0}, 1'b1,
          '{krt_pkg::ST_NOT_FOUND, 32'sh0, 32'h0, 8'd3}},
        '{'{krt_pkg::OP_UPDATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh8000_0000, 32'h0000_0000, 8'd3}},
        '{'{krt_pkg::OP_SEARCH, 32'sh8000_0000, 32'sh0, 32'h0}, 1'b0, '0},
        // drain to empty
        '{'{krt_pkg::OP_DELETE, 32'sh7FFF_FFFF, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd2}},
        '{'{krt_pkg::OP_DELETE, 32'sh0000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd1}},
        '{'{krt_pkg::OP_DELETE, 32'sh8000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_OK, 32'sh0, 32'h0, 8'd0}},
        '{'{krt_pkg::OP_SEARCH, 32'sh8000_0000, 32'sh0, 32'h0}, 1'b1,
          '{krt_pkg::ST_NOT_FOUND, 32'sh0, 32'h0, 8'd0}}
    };

    // Apply one request to the shadow table and return the reply it should produce
    function automatic t_reply apply_to_table(input t_request req);
        t_reply reply;
        int     slot;
        reply = '0;
        reply.status = krt_pkg::ST_OK;
        slot = -1;
        // linear scan, first match wins
        for (int i = 0; i < int'(record_total); i++) begin
            if (slot < 0 && record_model[i].key == req.key)
                slot = i;
        end
        if (req.op == krt_pkg::OP_ADD) begin
            if (record_total == krt_pkg::TABLE_DEPTH) begin
                reply.status = krt_pkg::ST_FULL;
            end else if (slot >= 0) begin
                reply.status = krt_pkg::ST_DUPLICATE;
            end else begin
                record_model[record_total] = '{price: req.price, quantity: req.quantity,
                                               key: req.key};
                record_total++;
            end
        end else if (slot < 0) begin
            reply.status = krt_pkg::ST_NOT_FOUND;
        end else begin
            case (req.op)
                krt_pkg::OP_SEARCH: begin
                    reply.quantity = record_model[slot].quantity;
                    reply.price    = record_model[slot].price;
                end
                krt_pkg::OP_UPDATE: begin
                    reply.quantity = record_model[slot].quantity;
                    reply.price    = record_model[slot].price;
                    record_model[slot].quantity = req.quantity;
                end
                default: begin
                    // delete: compact the later records down one slot
                    for (int j = slot; j + 1 < int'(record_total); j++)
                        record_model[j] = record_model[j + 1];
                    record_total--;
                end
            endcase
        end
        reply.fill = krt_pkg::FILL_W'(record_total);
        return reply;
    endfunction

    // Random request; sweeps the table between empty and full
    function automatic t_request random_request();
        t_request    req;
        int unsigned pick;
        int unsigned hit_pct;
        if (table_filling && record_total == krt_pkg::TABLE_DEPTH && $urandom_range(3) == 0)
            table_filling = 1'b0;
        else if (!table_filling && record_total == 0)
            table_filling = 1'b1;
        pick = $urandom_range(99);
        if (table_filling)
            req.op = (pick < 55) ? krt_pkg::OP_ADD :
                     (pick < 75) ? krt_pkg::OP_SEARCH :
                     (pick < 88) ? krt_pkg::OP_UPDATE : krt_pkg::OP_DELETE;
        else
            req.op = (pick < 10) ? krt_pkg::OP_ADD :
                     (pick < 35) ? krt_pkg::OP_SEARCH :
                     (pick < 50) ? krt_pkg::OP_UPDATE : krt_pkg::OP_DELETE;
        // adds mostly bring new keys, the rest mostly hit stored ones
        hit_pct = (req.op == krt_pkg::OP_ADD) ? 15 : 80;
        pick = $urandom_range(99);
        if (record_total != 0 && pick < hit_pct)
            req.key = record_model[$urandom_range(record_total - 1)].key;
        else if (pick < hit_pct + (100 - hit_pct) / 2)
            req.key = $signed($urandom_range(511)) - 256;
        else
            req.key = $urandom();
        req.quantity = $urandom();
        req.price    = $urandom();
        return req;
    endfunction

    // Drive one request, wait for its transaction, then record the reply it owes
    task automatic issue_request(input t_request req, input logic has_reply,
                                 input t_reply reply);
        t_reply predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {req.price, req.quantity, req.key};
        i_s_axis_tuser  <= req.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = apply_to_table(req);
        expected_replies.push_back(has_reply ? reply : predicted);
    endtask

    // Hold off the sender until every outstanding reply is back
    task automatic drain_replies();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_replies.size() != 0);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random back-pressure and reply checking
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        i_m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tdata[63:32],
                    o_m_axis_tdata[71:64]};
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_replies.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("found_quantity", want.quantity, got.quantity);
                check_field("found_price_bits", want.price, got.price);
                check_field("fill_level", 32'(want.fill), 32'(got.fill));
            end
        end
    end

    // Stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            issue_request(directed_rows[r].req, directed_rows[r].has_reply,
                          directed_rows[r].reply);

        // three back-pressure profiles: receiver idle, sender idle, none
        for (int phase = 0; phase < 3; phase++) begin
            drain_replies();
            case (phase)
                0: begin
                    sender_idle_pct   = 26;
                    receiver_idle_pct = 82;
                end
                1: begin
                    sender_idle_pct   = 82;
                    receiver_idle_pct = 26;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 400; n++) begin
                if ($urandom_range(63) == 0)
                    drain_replies();
                issue_request(random_request(), 1'b0, '0);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (4 * krt_pkg::TABLE_DEPTH + 16) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
